@@ rtl/core/kgc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the key gesture classifier
package kgc_pkg;

  // level change queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  // item operation codes
  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // gesture tracking states
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PRESSED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_REPRESSED = 3'd3,
    ST_HELD      = 3'd4
  } gesture_t;

  // reported events
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_CLICK  = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_LONG   = 3'd5,
    EV_REPEAT = 3'd6
  } event_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CLICK     = 2'd0,
    CFG_LONGPRESS = 2'd1,
    CFG_REPEAT    = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] CLICK_RESET  = 16'd200;
  localparam logic [15:0] LONG_RESET   = 16'd500;
  localparam logic [15:0] REPEAT_RESET = 16'd100;
  localparam logic [15:0] CLICK_MIN    = 16'd20;
  localparam logic [15:0] LONG_MIN     = 16'd50;

  // one queued level change
  typedef struct packed {
    logic        level;
    logic [31:0] stamp;
  } qentry_t;

  // queue requests from the control logic
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    clear;
    qentry_t wdata;
  } qctl_t;

  // queue status back to the control logic
  typedef struct packed {
    logic    empty;
    logic    full;
    qentry_t head;
  } qstat_t;

  // ring pointer advance with wrap at the queue depth
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // a is strictly later than b in wrapping 32-bit time
  function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

@@ rtl/core/kgc_queue.sv @@
`timescale 1ns / 1ps
// ring queue of level changes held in a memory with a registered head read
module kgc_queue
  import kgc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qctl_t  ctl,
  output qstat_t stat
);

  qentry_t mem [QUEUE_DEPTH];

  ptr_t    wr_ptr;
  ptr_t    rd_ptr;
  ptr_t    wr_ptr_next;
  ptr_t    rd_ptr_next;
  qentry_t rd_data;
  qentry_t fwd_data;
  logic    fwd;

  // pointer updates
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (ctl.clear) begin
      wr_ptr_next = '0;
      rd_ptr_next = '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_next = ptr_inc(wr_ptr);
      end
      if (ctl.pop) begin
        rd_ptr_next = ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= ctl.wdata;
    end
  end

  // read ahead at the next head, bypassing a write to that same entry
  always_ff @(posedge clk) begin
    rd_data  <= mem[rd_ptr_next];
    fwd_data <= ctl.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= ctl.push && (wr_ptr == rd_ptr_next);
    end
  end

  // status
  assign stat.head  = fwd ? fwd_data : rd_data;
  assign stat.empty = (rd_ptr == wr_ptr);
  assign stat.full  = (ptr_inc(wr_ptr) == rd_ptr);

endmodule

@@ rtl/core/key_gesture_classifier_core.sv @@
`timescale 1ns / 1ps
// key gesture classifier top level: feed queue, gesture tracking and result buffer
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   in       | in_valid / in_stall       | op, key_pressed, time_ms
//   out      | out_valid / out_stall     | accepted, event_res
//   config   | cfg_wr_en                 | cfg_index, cfg_wr_data
//
// One item per cycle while in_stall is low; its result is registered in the
// output register, or in the skid entry while the output is stalled. The queue
// memory takes one write and one registered head read per cycle, with the head
// read ahead with a bypass on a write to it. Reset clears pointers, state and the
// output buffer; the memory is not swept, so items are accepted right after reset.
// in_stall rises only when both the output register and the skid entry hold
// results that the receiver has not taken.
module key_gesture_classifier_core
  import kgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic        key_pressed,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [2:0]  event_res,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] click_timeout;
  logic [15:0] longpress_timeout;
  logic [15:0] repeat_timeout;

  gesture_t    gesture_state;
  gesture_t    gesture_next;
  logic [31:0] press_time;
  logic [31:0] press_time_next;
  logic [31:0] repeat_time;
  logic [31:0] repeat_time_next;
  logic        pending_double;
  logic        pending_next;
  logic        last_valid;
  logic        last_level;

  qctl_t       qctl;
  qstat_t      qstat;

  op_t         op_code;
  logic        take;
  logic        is_feed;
  logic        is_poll;
  logic        is_clear;
  logic        same_level;
  logic        push;
  logic        step;
  logic        have;
  logic        lvl;
  logic [31:0] ts;
  logic        long_due;
  logic        click_due;
  logic        repeat_due;
  logic        res_acc;
  event_t      res_ev;

  logic        skid_valid;
  logic        skid_accepted;
  logic [2:0]  skid_event;
  logic        out_load;

  // configuration registers with their minimum clamps
  always_ff @(posedge clk) begin
    if (rst) begin
      click_timeout     <= CLICK_RESET;
      longpress_timeout <= LONG_RESET;
      repeat_timeout    <= REPEAT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLICK:     click_timeout     <= (cfg_wr_data < CLICK_MIN) ? CLICK_MIN : cfg_wr_data;
        CFG_LONGPRESS: longpress_timeout <= (cfg_wr_data < LONG_MIN) ? LONG_MIN : cfg_wr_data;
        CFG_REPEAT:    repeat_timeout    <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  // item decode
  assign op_code  = op_t'(op);
  assign take     = in_valid && !in_stall;
  assign is_feed  = take && (op_code == OP_FEED);
  assign is_poll  = take && (op_code == OP_POLL);
  assign is_clear = take && (op_code == OP_CLEAR);

  // feed path: drop repeated levels, queue new ones while there is room
  assign same_level = last_valid && (last_level == key_pressed);
  assign push       = is_feed && !same_level && !qstat.full;

  // poll path: a pending double click preempts the dequeue and the step
  assign step = is_poll && !pending_double;
  assign have = step && !qstat.empty;
  assign lvl  = qstat.head.level;
  assign ts   = qstat.head.stamp;

  assign qctl.push  = push;
  assign qctl.pop   = have;
  assign qctl.clear = is_clear;
  assign qctl.wdata = '{level: key_pressed, stamp: time_ms};

  kgc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .stat (qstat)
  );

  // timeout checks against the poll time
  assign long_due   = is_after(time_ms, press_time + {16'd0, longpress_timeout});
  assign click_due  = is_after(time_ms, press_time + {16'd0, click_timeout});
  assign repeat_due = (repeat_timeout != 16'd0) &&
                      is_after(time_ms, repeat_time + {16'd0, repeat_timeout});

  // gesture next state
  always_comb begin
    gesture_next = gesture_state;
    if (is_clear) begin
      gesture_next = ST_IDLE;
    end else if (step) begin
      unique case (gesture_state)
        ST_IDLE: begin
          if (have && lvl) gesture_next = ST_PRESSED;
        end
        ST_PRESSED: begin
          if (have && !lvl) gesture_next = ST_RELEASED;
          else if (long_due) gesture_next = ST_HELD;
        end
        ST_REPRESSED: begin
          if (have && !lvl) gesture_next = ST_IDLE;
          else if (long_due) gesture_next = ST_HELD;
        end
        ST_RELEASED: begin
          if (have && lvl) gesture_next = ST_REPRESSED;
          else if (click_due) gesture_next = ST_IDLE;
        end
        ST_HELD: begin
          if (have && !lvl) gesture_next = ST_IDLE;
        end
        default: gesture_next = gesture_state;
      endcase
    end
  end

  // events and timestamp updates
  always_comb begin
    res_ev           = EV_NONE;
    press_time_next  = press_time;
    repeat_time_next = repeat_time;
    pending_next     = pending_double;
    if (is_clear) begin
      press_time_next  = 32'd0;
      repeat_time_next = 32'd0;
      pending_next     = 1'b0;
    end else if (is_poll && pending_double) begin
      res_ev       = EV_DOUBLE;
      pending_next = 1'b0;
    end else if (step) begin
      unique case (gesture_state)
        ST_IDLE: begin
          if (have && lvl) begin
            press_time_next = ts;
            res_ev          = EV_DOWN;
          end
        end
        ST_PRESSED, ST_REPRESSED: begin
          if (have && !lvl) begin
            if (gesture_state == ST_PRESSED) press_time_next = ts;
            else pending_next = 1'b1;
            res_ev = EV_UP;
          end else if (long_due) begin
            repeat_time_next = time_ms;
            res_ev           = EV_LONG;
          end
        end
        ST_RELEASED: begin
          if (have && lvl) begin
            press_time_next = ts;
            res_ev          = EV_DOWN;
          end else if (click_due) begin
            res_ev = EV_CLICK;
          end
        end
        ST_HELD: begin
          if (have && !lvl) begin
            res_ev = EV_UP;
          end else if (repeat_due) begin
            repeat_time_next = time_ms;
            res_ev           = EV_REPEAT;
          end
        end
        default: res_ev = EV_NONE;
      endcase
    end
  end

  // accepted flag of the item result
  always_comb begin
    unique case (op_code)
      OP_FEED:  res_acc = same_level || !qstat.full;
      OP_POLL:  res_acc = 1'b1;
      OP_CLEAR: res_acc = 1'b1;
      default:  res_acc = 1'b0;
    endcase
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_state  <= ST_IDLE;
      press_time     <= 32'd0;
      repeat_time    <= 32'd0;
      pending_double <= 1'b0;
      last_valid     <= 1'b0;
      last_level     <= 1'b0;
    end else begin
      gesture_state  <= gesture_next;
      press_time     <= press_time_next;
      repeat_time    <= repeat_time_next;
      pending_double <= pending_next;
      if (is_clear) begin
        last_valid <= 1'b0;
        last_level <= 1'b0;
      end else if (push) begin
        last_valid <= 1'b1;
        last_level <= key_pressed;
      end
    end
  end

  // output register with one skid entry behind it
  assign out_load = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted  <= skid_valid ? skid_accepted : res_acc;
      event_res <= skid_valid ? skid_event : res_ev;
    end else if (take) begin
      skid_accepted <= res_acc;
      skid_event    <= res_ev;
    end
  end

endmodule

@@ rtl/core/kgc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the key gesture classifier and their bind
module kgc_checker
  import kgc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       accepted,
  input logic [2:0] event_res
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(accepted) && $stable(event_res))
    else $error("result payload changed while stalled");

  // input stalls only behind a full output register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // a rejected or ignored item reports no event
  a_reject_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> event_res == EV_NONE)
    else $error("event reported for a rejected item");

  // reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output buffer not empty after reset");

endmodule

bind key_gesture_classifier_core kgc_checker u_kgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .accepted  (accepted),
  .event_res (event_res)
);

@@ tb/tb_key_gesture_classifier_core.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the key gesture classifier core
module tb_key_gesture_classifier_core;
  import kgc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;

  // one result item: accept flag and reported gesture
  typedef struct packed {
    logic   acc;
    event_t ev;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_FEED;
  logic        key_pressed = 1'b0;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic [2:0]  event_res;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_CLICK;
  logic [15:0] cfg_wr_data = '0;

  key_gesture_classifier_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .key_pressed (key_pressed),
    .time_ms     (time_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .event_res   (event_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // gesture tracker state mirrored by the testbench
  logic [31:0] ring_stamp [QUEUE_DEPTH];
  logic        ring_level [QUEUE_DEPTH];
  ptr_t        wr_ptr = '0;
  ptr_t        rd_ptr = '0;
  logic        lvl_known = 1'b0;
  logic        lvl_last = 1'b0;
  logic [31:0] press_at = '0;
  logic [31:0] repeat_at = '0;
  gesture_t    gesture = ST_IDLE;
  logic        dbl_owed = 1'b0;
  logic [15:0] click_ms = CLICK_RESET;
  logic [15:0] long_ms = LONG_RESET;
  logic [15:0] rep_ms = REPEAT_RESET;

  outcome_t    results_due [$];
  outcome_t    head_due;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  logic [31:0] clock_ms = '0;
  logic        key_lv = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_key_gesture_classifier_core: done, errors");
      $finish;
    end
  end

  // strict wrapping comparison: a lies after b
  function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic void clear_tracker();
    wr_ptr    = '0;
    rd_ptr    = '0;
    lvl_known = 1'b0;
    lvl_last  = 1'b0;
    press_at  = '0;
    repeat_at = '0;
    gesture   = ST_IDLE;
    dbl_owed  = 1'b0;
  endfunction

  // one poll: take at most one level change and advance the gesture
  function automatic event_t step_gesture(input logic [31:0] now);
    logic        have;
    logic        lv;
    logic [31:0] ts;
    event_t      ev;
    have = 1'b0;
    lv   = 1'b0;
    ts   = '0;
    ev   = EV_NONE;
    if (dbl_owed) begin
      dbl_owed = 1'b0;
      return EV_DOUBLE;
    end
    if (rd_ptr != wr_ptr) begin
      have   = 1'b1;
      lv     = ring_level[rd_ptr];
      ts     = ring_stamp[rd_ptr];
      rd_ptr = ring_next(rd_ptr);
    end
    case (gesture)
      ST_IDLE: begin
        if (have && lv) begin
          press_at = ts;
          gesture  = ST_PRESSED;
          ev       = EV_DOWN;
        end
      end
      ST_PRESSED, ST_REPRESSED: begin
        if (have && !lv) begin
          if (gesture == ST_PRESSED) begin
            press_at = ts;
            gesture  = ST_RELEASED;
          end else begin
            gesture  = ST_IDLE;
            dbl_owed = 1'b1;
          end
          ev = EV_UP;
        end else if (later_than(now, press_at + {16'd0, long_ms})) begin
          gesture   = ST_HELD;
          repeat_at = now;
          ev        = EV_LONG;
        end
      end
      ST_RELEASED: begin
        if (have && lv) begin
          press_at = ts;
          gesture  = ST_REPRESSED;
          ev       = EV_DOWN;
        end else if (later_than(now, press_at + {16'd0, click_ms})) begin
          gesture = ST_IDLE;
          ev      = EV_CLICK;
        end
      end
      ST_HELD: begin
        if (have && !lv) begin
          gesture = ST_IDLE;
          ev      = EV_UP;
        end else if (rep_ms != 16'd0 && later_than(now, repeat_at + {16'd0, rep_ms})) begin
          repeat_at = now;
          ev        = EV_REPEAT;
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  // result that one accepted item produces
  function automatic outcome_t classify_item(input logic [1:0] kind, input logic lv,
                                             input logic [31:0] t);
    outcome_t r;
    ptr_t     nx;
    r.acc = 1'b0;
    r.ev  = EV_NONE;
    case (kind)
      OP_FEED: begin
        if (lvl_known && lvl_last == lv) begin
          r.acc = 1'b1;
        end else begin
          nx = ring_next(wr_ptr);
          // ring keeps one slot free; a rejected level is not remembered
          if (nx != rd_ptr) begin
            ring_stamp[wr_ptr] = t;
            ring_level[wr_ptr] = lv;
            wr_ptr    = nx;
            lvl_known = 1'b1;
            lvl_last  = lv;
            r.acc     = 1'b1;
          end
        end
      end
      OP_POLL: begin
        r.ev  = step_gesture(t);
        r.acc = 1'b1;
      end
      OP_CLEAR: begin
        clear_tracker();
        r.acc = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // receiver: random stall and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result with no item waiting: accepted %0d, event_res %0d",
                 accepted, event_res);
          err_cnt++;
        end else begin
          head_due = results_due.pop_front();
          if (accepted !== head_due.acc) begin
            $error("accepted: expected %0d, actual %0d", head_due.acc, accepted);
            err_cnt++;
          end
          if (event_res !== head_due.ev) begin
            $error("event_res: expected %0d, actual %0d", head_due.ev, event_res);
            err_cnt++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // sender: optional idle cycles, then one item held until taken
  task automatic send_item(input logic [1:0] kind, input logic lv, input logic [31:0] t);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= kind;
    key_pressed <= lv;
    time_ms     <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(classify_item(kind, lv, t));
  endtask

  // stop sending and let every pending result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    // low writes are raised to the minimum
    case (idx)
      CFG_CLICK:     click_ms = (val < CLICK_MIN) ? CLICK_MIN : val;
      CFG_LONGPRESS: long_ms  = (val < LONG_MIN) ? LONG_MIN : val;
      CFG_REPEAT:    rep_ms   = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] c, input logic [15:0] l,
                              input logic [15:0] r);
    wait_drained();
    write_reg(CFG_CLICK, c);
    write_reg(CFG_LONGPRESS, l);
    write_reg(CFG_REPEAT, r);
  endtask

  task automatic set_pacing(input int snd_pct, input int rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
  endtask

  // time step between items, clustered around the timeouts
  function automatic logic [31:0] gap_ms();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(15);
      4: return {16'd0, click_ms} + $urandom_range(2) - 1;
      5: return {16'd0, long_ms} + $urandom_range(2) - 1;
      6: return {16'd0, rep_ms} + $urandom_range(2) - 1;
      7: return $urandom_range(1000);
      8: return 32'd0;
      default: begin
        // rare jump across half the time range
        if ($urandom_range(19) == 0) return 32'h7FFF_FFFF + $urandom_range(2);
        return $urandom_range(40);
      end
    endcase
  endfunction

  // random key activity: mostly press and release with polls, some noise
  task automatic run_gestures(input int n);
    int pick;
    int flood_left;
    flood_left = 0;
    clock_ms = $urandom;
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + gap_ms();
      if (flood_left > 0) begin
        // burst of level changes with no polls can fill the ring
        flood_left--;
        key_lv = ~key_lv;
        send_item(OP_FEED, key_lv, clock_ms);
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          key_lv = ~key_lv;
          send_item(OP_FEED, key_lv, clock_ms - $urandom_range(3));
        end else if (pick < 35) begin
          send_item(OP_FEED, key_lv, clock_ms);
        end else if (pick < 85) begin
          send_item(OP_POLL, 1'($urandom_range(1)), clock_ms);
        end else if (pick < 87) begin
          send_item(OP_CLEAR, 1'($urandom_range(1)), $urandom);
        end else if (pick < 89) begin
          send_item(OP_UNUSED, 1'($urandom_range(1)), $urandom);
        end else if (pick < 91) begin
          send_item(OP_FEED, 1'($urandom_range(1)), $urandom);
        end else if (pick < 93) begin
          send_item(OP_POLL, 1'($urandom_range(1)), $urandom);
        end else if (pick < 95) begin
          flood_left = $urandom_range(14, 20);
          send_item(OP_POLL, 1'b0, clock_ms);
        end else begin
          send_item(OP_POLL, 1'b0, clock_ms);
        end
      end
    end
  endtask

  // empty poll, unused op, repeated level, single click at the timeout edge
  task automatic test_single_click();
    send_item(OP_POLL, 1'b0, 32'd0);
    send_item(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_FEED, 1'b1, 32'd100);
    send_item(OP_FEED, 1'b1, 32'd105);
    send_item(OP_FEED, 1'b0, 32'd150);
    send_item(OP_POLL, 1'b0, 32'd150);
    send_item(OP_POLL, 1'b0, 32'd150);
    send_item(OP_POLL, 1'b0, 32'd350);
    send_item(OP_POLL, 1'b0, 32'd351);
  endtask

  // long press and repeat with the deadline wrapping past zero
  task automatic test_long_press_wrap();
    send_item(OP_CLEAR, 1'b1, 32'd0);
    send_item(OP_FEED, 1'b1, 32'hFFFF_FF00);
    send_item(OP_POLL, 1'b0, 32'hFFFF_FF00);
    send_item(OP_POLL, 1'b0, 32'h0000_00F4);
    send_item(OP_POLL, 1'b0, 32'h0000_00F5);
    send_item(OP_POLL, 1'b0, 32'h0000_015A);
    send_item(OP_FEED, 1'b0, 32'h0000_0200);
    send_item(OP_POLL, 1'b0, 32'h0000_0200);
  endtask

  // ring overflow, rejected level retried, then a held-back double click
  task automatic test_queue_full_double();
    for (int i = 0; i < 17; i++) begin
      send_item(OP_FEED, (i == 16) ? 1'b0 : ~i[0], 32'd5000 + 32'd10 * i);
    end
    for (int i = 0; i < 5; i++) begin
      send_item(OP_POLL, 1'b0, 32'd5200);
    end
  endtask

  task automatic test_random_defaults();
    run_gestures(300);
  endtask

  // writes below the minimums, repeat off and at its smallest
  task automatic test_config_floors();
    apply_config(16'd0, 16'd0, 16'd0);
    run_gestures(200);
    apply_config(16'd19, 16'd49, 16'd1);
    run_gestures(150);
  endtask

  task automatic test_config_minimums();
    apply_config(CLICK_MIN, LONG_MIN, 16'd1);
    run_gestures(200);
  endtask

  task automatic test_config_ceilings();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gestures(150);
  endtask

  task automatic test_config_mixed();
    for (int k = 0; k < 3; k++) begin
      if (k == 0) begin
        apply_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
      end else begin
        apply_config(16'($urandom_range(300)), 16'($urandom_range(600)),
                     16'($urandom_range(150)));
      end
      run_gestures(100);
    end
    apply_config(CLICK_RESET, LONG_RESET, REPEAT_RESET);
    run_gestures(100);
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_pacing(37, 84);
    test_single_click();
    test_long_press_wrap();
    test_queue_full_double();
    test_random_defaults();
    test_config_floors();
    set_pacing(84, 37);
    test_config_minimums();
    test_config_ceilings();
    set_pacing(0, 0);
    test_config_mixed();
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_key_gesture_classifier_core: done, clean");
    end else begin
      $display("tb_key_gesture_classifier_core: done, errors");
    end
    $finish;
  end

endmodule
